// ===== src/bpa_pkg.sv =====
// bpa_pkg: shared types, constants and helper functions of the buddy page allocator.
// Used by buddy_page_allocator; bpa_ram needs nothing from it.
package bpa_pkg;

    localparam int TOP_ORDER    = 10;
    localparam int TABLE_FRAMES = 4096;
    localparam int PAGE_SHIFT   = 12;

    localparam int ADDR_W     = 32;
    localparam int COUNT_W    = 13;
    localparam int FADDR_W    = ADDR_W - PAGE_SHIFT;
    localparam int SUM_W      = FADDR_W + 1;
    localparam int FRAME_W    = $clog2(TABLE_FRAMES);
    localparam int LINK_W     = FRAME_W + 1;
    localparam int ORD_W      = 4;
    localparam int MARK_W     = 6;
    localparam int LIST_N     = TOP_ORDER + 1;
    localparam int LIST_IDX_W = $clog2(LIST_N);

    // mark layout: [5] free, [4] valid, [3:0] order
    localparam int MK_FREE  = 5;
    localparam int MK_VALID = 4;

    localparam logic [LINK_W-1:0] NIL      = LINK_W'(TABLE_FRAMES);
    localparam logic [ORD_W-1:0]  NO_ORDER = 4'hF;

    typedef enum logic [1:0] {
        CMD_INIT  = 2'd0,
        CMD_ALLOC = 2'd1,
        CMD_FREE  = 2'd2
    } cmd_t;

    typedef enum logic [2:0] {
        ST_OK            = 3'd0,
        ST_MISALIGNED    = 3'd1,
        ST_OUT_OF_REGION = 3'd2,
        ST_BAD_COUNT     = 3'd3,
        ST_NO_BLOCK      = 3'd4
    } status_t;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [ADDR_W-1:0]  byte_address;
        logic [COUNT_W-1:0] frame_count;
    } req_t;

    typedef struct packed {
        logic [2:0]        status;
        logic [ADDR_W-1:0] result_address;
    } rsp_t;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_CHECK,
        S_INIT_FILL,
        S_INIT_LAY,
        S_AL_MARK,
        S_AL_SPLIT,
        S_AL_KEEP,
        S_AL_REST,
        S_FR_PIECE,
        S_FR_NEXT,
        S_REL_RD,
        S_REL_WR,
        S_REL_BUD,
        S_REL_M1,
        S_SB_RD,
        S_SB_WR,
        S_LA_1,
        S_LA_2,
        S_LD_RD,
        S_LD_WR,
        S_RESP
    } state_t;

    // smallest order whose block holds n frames; TOP_ORDER+1 if none
    function automatic logic [ORD_W-1:0] round_order(input logic [COUNT_W-1:0] n);
        logic [ORD_W-1:0] r;
        r = ORD_W'(TOP_ORDER + 1);
        for (int o = TOP_ORDER; o >= 0; o--) begin
            if (((COUNT_W+1)'(1) << o) >= {1'b0, n})
                r = ORD_W'(o);
        end
        return r;
    endfunction

    // largest order aligned at frame f that still fits in r frames
    function automatic logic [ORD_W-1:0] lay_order(input logic [LINK_W-1:0] f,
                                                   input logic [COUNT_W-1:0] r);
        logic [ORD_W-1:0] res;
        res = '0;
        for (int o = 1; o <= TOP_ORDER; o++) begin
            if (((f & ((LINK_W'(1) << o) - LINK_W'(1))) == '0) &&
                ((COUNT_W'(1) << o) <= r))
                res = ORD_W'(o);
        end
        return res;
    endfunction

endpackage

// ===== src/buddy_page_allocator.sv =====
// buddy_page_allocator: top level of the page-frame buddy allocator.
// Depends on bpa_pkg and three bpa_ram instances (marks, next links, prev links).
//
//  channel | direction | handshake              | transaction payload
//  --------+-----------+------------------------+------------------------------
//  req     | in        | req_valid / req_ready  | bpa_pkg::req_t (cmd, addr, n)
//  rsp     | out       | rsp_valid / rsp_ready  | bpa_pkg::rsp_t (status, addr)
//
//  One transaction at a time. Each frame-mark or link access goes through a
//  synchronous RAM, so read-modify-write of a mark takes a read state and a write state.
//  Alloc splits level by level and, when n is not a power of two, keeps head
//  pieces and returns tail pieces; free releases each piece and merges level by
//  level; init fills the marks, then lays the blocks.
//  After reset a clearing pass writes all TABLE_FRAMES marks;
//  req_ready stays low until it ends.
//  A waiting response does not block: the next request is taken in IDLE; a new
//  response waits in RESP only while the output register is still full.
module buddy_page_allocator (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  bpa_pkg::req_t  req,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output bpa_pkg::rsp_t  rsp
);

    // ---------------------------------------------------------------- state
    bpa_pkg::state_t state_reg, state_next;
    bpa_pkg::state_t ret_reg,   ret_next;     // return point of mark/link routines
    logic            chain_reg, chain_next;   // mark write followed by list add
    logic            first_reg, first_next;   // first pass of a release

    logic [1:0]                  cmd_reg,  cmd_next;
    logic [bpa_pkg::ADDR_W-1:0]  addr_reg, addr_next;
    logic [bpa_pkg::COUNT_W-1:0] cnt_reg,  cnt_next;
    logic [bpa_pkg::LINK_W-1:0]  f_reg,    f_next;
    logic [bpa_pkg::LINK_W-1:0]  cur_reg,  cur_next;
    logic [bpa_pkg::COUNT_W-1:0] rem_reg,  rem_next;
    logic [bpa_pkg::ORD_W-1:0]   ord_reg,  ord_next;
    logic [bpa_pkg::ORD_W-1:0]   k_reg,    k_next;
    logic [bpa_pkg::ORD_W-1:0]   pc_reg,   pc_next;

    // arguments of the shared routines
    logic [bpa_pkg::FRAME_W-1:0] op_frame_reg, op_frame_next;
    logic [bpa_pkg::ORD_W-1:0]   op_ord_reg,   op_ord_next;
    logic                        op_free_reg,  op_free_next;
    logic [bpa_pkg::LINK_W-1:0]  lt_reg,       lt_next;

    logic [bpa_pkg::FRAME_W-1:0] clr_reg, clr_next;
    logic [2:0]                  status_reg, status_next;
    logic [bpa_pkg::ADDR_W-1:0]  result_reg, result_next;
    logic [bpa_pkg::ADDR_W-1:0]  rs_reg, rs_next;
    logic [bpa_pkg::ADDR_W-1:0]  re_reg, re_next;

    logic [bpa_pkg::LINK_W-1:0]  head_reg [bpa_pkg::LIST_N];
    logic [bpa_pkg::LINK_W-1:0]  head_next[bpa_pkg::LIST_N];
    logic [bpa_pkg::LINK_W-1:0]  tail_reg [bpa_pkg::LIST_N];
    logic [bpa_pkg::LINK_W-1:0]  tail_next[bpa_pkg::LIST_N];

    logic          rsp_valid_reg;
    bpa_pkg::rsp_t rsp_reg;

    // ---------------------------------------------------------------- memories
    logic                         mk_we, mk_re;
    logic [bpa_pkg::FRAME_W-1:0]  mk_waddr, mk_raddr;
    logic [bpa_pkg::MARK_W-1:0]   mk_wdata, mk_rd;
    logic                         nx_we, nx_re;
    logic [bpa_pkg::FRAME_W-1:0]  nx_waddr, nx_raddr;
    logic [bpa_pkg::LINK_W-1:0]   nx_wdata, nx_rd;
    logic                         pv_we, pv_re;
    logic [bpa_pkg::FRAME_W-1:0]  pv_waddr, pv_raddr;
    logic [bpa_pkg::LINK_W-1:0]   pv_wdata, pv_rd;

    bpa_ram #(.WIDTH(bpa_pkg::MARK_W), .DEPTH(bpa_pkg::TABLE_FRAMES)) u_marks (
        .clk(clk), .we(mk_we), .waddr(mk_waddr), .wdata(mk_wdata),
        .re(mk_re), .raddr(mk_raddr), .rdata(mk_rd)
    );

    bpa_ram #(.WIDTH(bpa_pkg::LINK_W), .DEPTH(bpa_pkg::TABLE_FRAMES)) u_next (
        .clk(clk), .we(nx_we), .waddr(nx_waddr), .wdata(nx_wdata),
        .re(nx_re), .raddr(nx_raddr), .rdata(nx_rd)
    );

    bpa_ram #(.WIDTH(bpa_pkg::LINK_W), .DEPTH(bpa_pkg::TABLE_FRAMES)) u_prev (
        .clk(clk), .we(pv_we), .waddr(pv_waddr), .wdata(pv_wdata),
        .re(pv_re), .raddr(pv_raddr), .rdata(pv_rd)
    );

    // ---------------------------------------------------------------- helpers
    logic [bpa_pkg::FADDR_W-1:0] f20;
    logic [bpa_pkg::SUM_W-1:0]   f_end;
    logic [bpa_pkg::ORD_W-1:0]   k_w;
    logic [bpa_pkg::ORD_W-1:0]   lay_w;
    logic [bpa_pkg::ORD_W-1:0]   rel_ord;
    logic                        rel_skip;
    logic [bpa_pkg::FRAME_W-1:0] rel_frm;
    logic [bpa_pkg::FRAME_W-1:0] bud_w;       // buddy at the order just read
    logic [bpa_pkg::FRAME_W-1:0] bd_w;        // buddy at ord_reg
    logic [bpa_pkg::FRAME_W-1:0] low_w;
    logic                        bud_match;
    logic [bpa_pkg::LINK_W-1:0]  lt_w;
    logic [bpa_pkg::LINK_W-1:0]  ld_p, ld_n;
    logic                        found_w;
    logic [bpa_pkg::ORD_W-1:0]   od_w;
    logic [bpa_pkg::LIST_IDX_W-1:0] op_idx;

    assign f20      = addr_reg[bpa_pkg::ADDR_W-1:bpa_pkg::PAGE_SHIFT];
    assign f_end    = {1'b0, f20} + bpa_pkg::SUM_W'(cnt_reg);
    assign k_w      = bpa_pkg::round_order(cnt_reg);
    assign lay_w    = bpa_pkg::lay_order(f_reg, rem_reg);
    assign rel_ord  = first_reg ? mk_rd[bpa_pkg::ORD_W-1:0] : ord_reg;
    assign rel_skip = first_reg &&
                      (mk_rd[bpa_pkg::ORD_W-1:0] > bpa_pkg::ORD_W'(bpa_pkg::TOP_ORDER));
    assign rel_frm  = f_reg[bpa_pkg::FRAME_W-1:0];
    assign bud_w    = rel_frm ^ (bpa_pkg::FRAME_W'(1) << rel_ord);
    assign bd_w     = rel_frm ^ (bpa_pkg::FRAME_W'(1) << ord_reg);
    assign low_w    = rel_frm & ~(bpa_pkg::FRAME_W'(1) << ord_reg);
    assign bud_match = (mk_rd[bpa_pkg::ORD_W-1:0] == ord_reg) &&
                       mk_rd[bpa_pkg::MK_VALID] && mk_rd[bpa_pkg::MK_FREE];
    assign op_idx   = op_ord_reg[bpa_pkg::LIST_IDX_W-1:0];
    assign lt_w     = tail_reg[op_idx];
    assign ld_p     = (pv_rd < bpa_pkg::NIL) ? pv_rd : bpa_pkg::NIL;
    assign ld_n     = (nx_rd < bpa_pkg::NIL) ? nx_rd : bpa_pkg::NIL;

    // lowest non-empty list at or above the rounded order
    always_comb
    begin
        found_w = 1'b0;
        od_w    = '0;
        for (int o = bpa_pkg::TOP_ORDER; o >= 0; o--) begin
            if ((bpa_pkg::ORD_W'(o) >= k_w) && (head_reg[o] != bpa_pkg::NIL)) begin
                found_w = 1'b1;
                od_w    = bpa_pkg::ORD_W'(o);
            end
        end
    end

    // ---------------------------------------------------------------- next state
    always_comb
    begin
        state_next    = state_reg;
        ret_next      = ret_reg;
        chain_next    = chain_reg;
        first_next    = first_reg;
        cmd_next      = cmd_reg;
        addr_next     = addr_reg;
        cnt_next      = cnt_reg;
        f_next        = f_reg;
        cur_next      = cur_reg;
        rem_next      = rem_reg;
        ord_next      = ord_reg;
        k_next        = k_reg;
        pc_next       = pc_reg;
        op_frame_next = op_frame_reg;
        op_ord_next   = op_ord_reg;
        op_free_next  = op_free_reg;
        lt_next       = lt_reg;
        clr_next      = clr_reg;
        status_next   = status_reg;
        result_next   = result_reg;
        rs_next       = rs_reg;
        re_next       = re_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;

        case (state_reg)
            bpa_pkg::S_CLEAR:
            begin
                clr_next = clr_reg + bpa_pkg::FRAME_W'(1);
                if (clr_reg == bpa_pkg::FRAME_W'(bpa_pkg::TABLE_FRAMES - 1))
                    state_next = bpa_pkg::S_IDLE;
            end

            bpa_pkg::S_IDLE:
            begin
                if (req_valid) begin
                    cmd_next   = req.cmd;
                    addr_next  = req.byte_address;
                    cnt_next   = req.frame_count;
                    state_next = bpa_pkg::S_CHECK;
                end
            end

            bpa_pkg::S_CHECK:
            begin
                status_next = bpa_pkg::ST_OK;
                result_next = '0;
                state_next  = bpa_pkg::S_RESP;
                case (cmd_reg)
                    bpa_pkg::CMD_INIT:
                    begin
                        if (addr_reg[bpa_pkg::PAGE_SHIFT-1:0] != '0)
                            status_next = bpa_pkg::ST_MISALIGNED;
                        else if (cnt_reg == '0)
                            status_next = bpa_pkg::ST_BAD_COUNT;
                        else if (f_end > bpa_pkg::SUM_W'(bpa_pkg::TABLE_FRAMES))
                            status_next = bpa_pkg::ST_OUT_OF_REGION;
                        else begin
                            rs_next = addr_reg;
                            re_next = addr_reg +
                                      (bpa_pkg::ADDR_W'(cnt_reg) << bpa_pkg::PAGE_SHIFT);
                            for (int o = 0; o < bpa_pkg::LIST_N; o++) begin
                                head_next[o] = bpa_pkg::NIL;
                                tail_next[o] = bpa_pkg::NIL;
                            end
                            op_frame_next = f20[bpa_pkg::FRAME_W-1:0];
                            f_next        = bpa_pkg::LINK_W'(f20[bpa_pkg::FRAME_W-1:0]);
                            rem_next      = cnt_reg;
                            state_next    = bpa_pkg::S_INIT_FILL;
                        end
                    end

                    bpa_pkg::CMD_ALLOC:
                    begin
                        if ((cnt_reg == '0) || (k_w > bpa_pkg::ORD_W'(bpa_pkg::TOP_ORDER)))
                            status_next = bpa_pkg::ST_BAD_COUNT;
                        else if (!found_w)
                            status_next = bpa_pkg::ST_NO_BLOCK;
                        else begin
                            f_next        = head_reg[od_w[bpa_pkg::LIST_IDX_W-1:0]];
                            ord_next      = od_w;
                            k_next        = k_w;
                            op_frame_next = head_reg[od_w[bpa_pkg::LIST_IDX_W-1:0]]
                                            [bpa_pkg::FRAME_W-1:0];
                            op_ord_next   = od_w;
                            ret_next      = bpa_pkg::S_AL_MARK;
                            state_next    = bpa_pkg::S_LD_RD;
                        end
                    end

                    bpa_pkg::CMD_FREE:
                    begin
                        if (!((rs_reg <= addr_reg) && (addr_reg < re_reg)))
                            status_next = bpa_pkg::ST_OUT_OF_REGION;
                        else if (addr_reg[bpa_pkg::PAGE_SHIFT-1:0] != '0)
                            status_next = bpa_pkg::ST_MISALIGNED;
                        else if ((cnt_reg == '0) ||
                                 (k_w > bpa_pkg::ORD_W'(bpa_pkg::TOP_ORDER)))
                            status_next = bpa_pkg::ST_BAD_COUNT;
                        else if (f_end > {1'b0, re_reg[bpa_pkg::ADDR_W-1:bpa_pkg::PAGE_SHIFT]})
                            status_next = bpa_pkg::ST_OUT_OF_REGION;
                        else begin
                            cur_next   = bpa_pkg::LINK_W'(f20[bpa_pkg::FRAME_W-1:0]);
                            pc_next    = bpa_pkg::ORD_W'(bpa_pkg::TOP_ORDER);
                            state_next = bpa_pkg::S_FR_PIECE;
                        end
                    end

                    default:
                    begin
                        state_next = bpa_pkg::S_RESP;
                    end
                endcase
            end

            bpa_pkg::S_INIT_FILL:
            begin
                op_frame_next = op_frame_reg + bpa_pkg::FRAME_W'(1);
                rem_next      = rem_reg - bpa_pkg::COUNT_W'(1);
                if (rem_reg == bpa_pkg::COUNT_W'(1)) begin
                    rem_next   = cnt_reg;
                    state_next = bpa_pkg::S_INIT_LAY;
                end
            end

            bpa_pkg::S_INIT_LAY:
            begin
                if (rem_reg == '0)
                    state_next = bpa_pkg::S_RESP;
                else begin
                    op_frame_next = f_reg[bpa_pkg::FRAME_W-1:0];
                    op_ord_next   = lay_w;
                    ret_next      = bpa_pkg::S_INIT_LAY;
                    f_next        = f_reg + (bpa_pkg::LINK_W'(1) << lay_w);
                    rem_next      = rem_reg - (bpa_pkg::COUNT_W'(1) << lay_w);
                    state_next    = bpa_pkg::S_LA_1;
                end
            end

            bpa_pkg::S_AL_MARK:
            begin
                op_frame_next = f_reg[bpa_pkg::FRAME_W-1:0];
                op_ord_next   = k_reg;
                op_free_next  = 1'b0;
                chain_next    = 1'b0;
                ret_next      = bpa_pkg::S_AL_SPLIT;
                state_next    = bpa_pkg::S_SB_RD;
            end

            bpa_pkg::S_AL_SPLIT:
            begin
                if (ord_reg > k_reg) begin
                    ord_next      = ord_reg - bpa_pkg::ORD_W'(1);
                    op_frame_next = bpa_pkg::FRAME_W'(f_reg +
                                    (bpa_pkg::LINK_W'(1) << (ord_reg - bpa_pkg::ORD_W'(1))));
                    op_ord_next   = ord_reg - bpa_pkg::ORD_W'(1);
                    op_free_next  = 1'b1;
                    chain_next    = 1'b1;
                    ret_next      = bpa_pkg::S_AL_SPLIT;
                    state_next    = bpa_pkg::S_SB_RD;
                end else begin
                    result_next = bpa_pkg::ADDR_W'(f_reg) << bpa_pkg::PAGE_SHIFT;
                    if (cnt_reg == (bpa_pkg::COUNT_W'(1) << k_reg))
                        state_next = bpa_pkg::S_RESP;
                    else begin
                        cur_next   = f_reg;
                        ord_next   = k_reg - bpa_pkg::ORD_W'(1);
                        state_next = bpa_pkg::S_AL_KEEP;
                    end
                end
            end

            // head pieces kept, falling size
            bpa_pkg::S_AL_KEEP:
            begin
                if (ord_reg == '0) begin
                    ret_next = bpa_pkg::S_AL_REST;
                    ord_next = '0;
                    rem_next = (bpa_pkg::COUNT_W'(1) << k_reg) - cnt_reg;
                end else begin
                    ret_next = bpa_pkg::S_AL_KEEP;
                    ord_next = ord_reg - bpa_pkg::ORD_W'(1);
                end
                if (cnt_reg[ord_reg]) begin
                    op_frame_next = cur_reg[bpa_pkg::FRAME_W-1:0];
                    op_ord_next   = ord_reg;
                    op_free_next  = 1'b0;
                    chain_next    = 1'b0;
                    cur_next      = cur_reg + (bpa_pkg::LINK_W'(1) << ord_reg);
                    state_next    = bpa_pkg::S_SB_RD;
                end else
                    state_next = (ord_reg == '0) ? bpa_pkg::S_AL_REST : bpa_pkg::S_AL_KEEP;
            end

            // tail pieces returned, rising size
            bpa_pkg::S_AL_REST:
            begin
                ret_next = (ord_reg == k_reg - bpa_pkg::ORD_W'(1)) ?
                           bpa_pkg::S_RESP : bpa_pkg::S_AL_REST;
                ord_next = ord_reg + bpa_pkg::ORD_W'(1);
                if (rem_reg[ord_reg]) begin
                    op_frame_next = cur_reg[bpa_pkg::FRAME_W-1:0];
                    op_ord_next   = ord_reg;
                    op_free_next  = 1'b1;
                    chain_next    = 1'b1;
                    cur_next      = cur_reg + (bpa_pkg::LINK_W'(1) << ord_reg);
                    state_next    = bpa_pkg::S_SB_RD;
                end else
                    state_next = (ord_reg == k_reg - bpa_pkg::ORD_W'(1)) ?
                                 bpa_pkg::S_RESP : bpa_pkg::S_AL_REST;
            end

            bpa_pkg::S_FR_PIECE:
            begin
                if (cnt_reg[pc_reg]) begin
                    f_next     = cur_reg;
                    cur_next   = cur_reg + (bpa_pkg::LINK_W'(1) << pc_reg);
                    first_next = 1'b1;
                    state_next = bpa_pkg::S_REL_RD;
                end else
                    state_next = bpa_pkg::S_FR_NEXT;
            end

            bpa_pkg::S_FR_NEXT:
            begin
                if (pc_reg == '0)
                    state_next = bpa_pkg::S_RESP;
                else begin
                    pc_next    = pc_reg - bpa_pkg::ORD_W'(1);
                    state_next = bpa_pkg::S_FR_PIECE;
                end
            end

            bpa_pkg::S_REL_RD:
            begin
                state_next = bpa_pkg::S_REL_WR;
            end

            bpa_pkg::S_REL_WR:
            begin
                if (rel_skip)
                    state_next = bpa_pkg::S_FR_NEXT;
                else begin
                    first_next = 1'b0;
                    ord_next   = rel_ord;
                    if (rel_ord >= bpa_pkg::ORD_W'(bpa_pkg::TOP_ORDER)) begin
                        op_frame_next = rel_frm;
                        op_ord_next   = rel_ord;
                        ret_next      = bpa_pkg::S_FR_NEXT;
                        state_next    = bpa_pkg::S_LA_1;
                    end else
                        state_next = bpa_pkg::S_REL_BUD;
                end
            end

            bpa_pkg::S_REL_BUD:
            begin
                if (!bud_match) begin
                    op_frame_next = rel_frm;
                    op_ord_next   = ord_reg;
                    ret_next      = bpa_pkg::S_FR_NEXT;
                    state_next    = bpa_pkg::S_LA_1;
                end else begin
                    op_frame_next = bd_w;
                    op_ord_next   = ord_reg;
                    ret_next      = bpa_pkg::S_REL_M1;
                    state_next    = bpa_pkg::S_LD_RD;
                end
            end

            // merged: upper half loses its head mark, lower half carries on
            bpa_pkg::S_REL_M1:
            begin
                op_frame_next = low_w | (bpa_pkg::FRAME_W'(1) << ord_reg);
                op_ord_next   = bpa_pkg::NO_ORDER;
                op_free_next  = 1'b0;
                chain_next    = 1'b0;
                ret_next      = bpa_pkg::S_REL_RD;
                f_next        = bpa_pkg::LINK_W'(low_w);
                ord_next      = ord_reg + bpa_pkg::ORD_W'(1);
                state_next    = bpa_pkg::S_SB_RD;
            end

            bpa_pkg::S_SB_RD:
            begin
                state_next = bpa_pkg::S_SB_WR;
            end

            bpa_pkg::S_SB_WR:
            begin
                if (chain_reg) begin
                    chain_next = 1'b0;
                    state_next = bpa_pkg::S_LA_1;
                end else
                    state_next = ret_reg;
            end

            bpa_pkg::S_LA_1:
            begin
                tail_next[op_idx] = bpa_pkg::LINK_W'(op_frame_reg);
                if (lt_w == bpa_pkg::NIL) begin
                    head_next[op_idx] = bpa_pkg::LINK_W'(op_frame_reg);
                    state_next        = ret_reg;
                end else begin
                    lt_next    = lt_w;
                    state_next = bpa_pkg::S_LA_2;
                end
            end

            bpa_pkg::S_LA_2:
            begin
                state_next = ret_reg;
            end

            bpa_pkg::S_LD_RD:
            begin
                state_next = bpa_pkg::S_LD_WR;
            end

            bpa_pkg::S_LD_WR:
            begin
                if (ld_p == bpa_pkg::NIL)
                    head_next[op_idx] = ld_n;
                if (ld_n == bpa_pkg::NIL)
                    tail_next[op_idx] = ld_p;
                state_next = ret_reg;
            end

            bpa_pkg::S_RESP:
            begin
                if (!rsp_valid_reg || rsp_ready)
                    state_next = bpa_pkg::S_IDLE;
            end

            default:
            begin
                state_next = bpa_pkg::S_IDLE;
            end
        endcase
    end

    // ---------------------------------------------------------------- outputs
    always_comb
    begin
        mk_we    = 1'b0;
        mk_waddr = '0;
        mk_wdata = '0;
        mk_re    = 1'b0;
        mk_raddr = '0;
        nx_we    = 1'b0;
        nx_waddr = '0;
        nx_wdata = '0;
        nx_re    = 1'b0;
        nx_raddr = '0;
        pv_we    = 1'b0;
        pv_waddr = '0;
        pv_wdata = '0;
        pv_re    = 1'b0;
        pv_raddr = '0;

        case (state_reg)
            bpa_pkg::S_CLEAR:
            begin
                mk_we    = 1'b1;
                mk_waddr = clr_reg;
            end

            bpa_pkg::S_INIT_FILL:
            begin
                mk_we    = 1'b1;
                mk_waddr = op_frame_reg;
                mk_wdata = {1'b1, 1'b1, bpa_pkg::NO_ORDER};
            end

            bpa_pkg::S_INIT_LAY:
            begin
                if (rem_reg != '0) begin
                    mk_we    = 1'b1;
                    mk_waddr = f_reg[bpa_pkg::FRAME_W-1:0];
                    mk_wdata = {1'b1, 1'b1, lay_w};
                end
            end

            bpa_pkg::S_SB_RD:
            begin
                mk_re    = 1'b1;
                mk_raddr = op_frame_reg;
            end

            bpa_pkg::S_SB_WR:
            begin
                mk_we    = 1'b1;
                mk_waddr = op_frame_reg;
                mk_wdata = {op_free_reg, mk_rd[bpa_pkg::MK_VALID], op_ord_reg};
            end

            bpa_pkg::S_REL_RD:
            begin
                mk_re    = 1'b1;
                mk_raddr = rel_frm;
            end

            bpa_pkg::S_REL_WR:
            begin
                if (!rel_skip) begin
                    mk_we    = 1'b1;
                    mk_waddr = rel_frm;
                    mk_wdata = {1'b1, mk_rd[bpa_pkg::MK_VALID], rel_ord};
                    if (rel_ord < bpa_pkg::ORD_W'(bpa_pkg::TOP_ORDER)) begin
                        mk_re    = 1'b1;
                        mk_raddr = bud_w;
                    end
                end
            end

            bpa_pkg::S_LA_1:
            begin
                nx_we    = 1'b1;
                nx_waddr = op_frame_reg;
                nx_wdata = bpa_pkg::NIL;
                pv_we    = 1'b1;
                pv_waddr = op_frame_reg;
                pv_wdata = lt_w;
            end

            bpa_pkg::S_LA_2:
            begin
                nx_we    = 1'b1;
                nx_waddr = lt_reg[bpa_pkg::FRAME_W-1:0];
                nx_wdata = bpa_pkg::LINK_W'(op_frame_reg);
            end

            bpa_pkg::S_LD_RD:
            begin
                nx_re    = 1'b1;
                nx_raddr = op_frame_reg;
                pv_re    = 1'b1;
                pv_raddr = op_frame_reg;
            end

            bpa_pkg::S_LD_WR:
            begin
                if (ld_p != bpa_pkg::NIL) begin
                    nx_we    = 1'b1;
                    nx_waddr = ld_p[bpa_pkg::FRAME_W-1:0];
                    nx_wdata = ld_n;
                end
                if (ld_n != bpa_pkg::NIL) begin
                    pv_we    = 1'b1;
                    pv_waddr = ld_n[bpa_pkg::FRAME_W-1:0];
                    pv_wdata = ld_p;
                end
            end

            default:
            begin
                mk_we = 1'b0;
            end
        endcase
    end

    assign req_ready = (state_reg == bpa_pkg::S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // ---------------------------------------------------------------- registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= bpa_pkg::S_CLEAR;
            ret_reg       <= bpa_pkg::S_IDLE;
            chain_reg     <= 1'b0;
            first_reg     <= 1'b0;
            clr_reg       <= '0;
            rs_reg        <= '0;
            re_reg        <= '0;
            rsp_valid_reg <= 1'b0;
            for (int o = 0; o < bpa_pkg::LIST_N; o++) begin
                head_reg[o] <= bpa_pkg::NIL;
                tail_reg[o] <= bpa_pkg::NIL;
            end
        end else begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            chain_reg <= chain_next;
            first_reg <= first_next;
            clr_reg   <= clr_next;
            rs_reg    <= rs_next;
            re_reg    <= re_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            if ((state_reg == bpa_pkg::S_RESP) && (!rsp_valid_reg || rsp_ready))
                rsp_valid_reg <= 1'b1;
            else if (rsp_ready)
                rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        addr_reg     <= addr_next;
        cnt_reg      <= cnt_next;
        f_reg        <= f_next;
        cur_reg      <= cur_next;
        rem_reg      <= rem_next;
        ord_reg      <= ord_next;
        k_reg        <= k_next;
        pc_reg       <= pc_next;
        op_frame_reg <= op_frame_next;
        op_ord_reg   <= op_ord_next;
        op_free_reg  <= op_free_next;
        lt_reg       <= lt_next;
        status_reg   <= status_next;
        result_reg   <= result_next;
        if ((state_reg == bpa_pkg::S_RESP) && (!rsp_valid_reg || rsp_ready)) begin
            rsp_reg.status         <= status_reg;
            rsp_reg.result_address <= result_reg;
        end
    end

    // ---------------------------------------------------------------- checks
`ifndef SYNTHESIS
    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.status <= 3'(bpa_pkg::ST_NO_BLOCK)))
        else $error("response status out of range");

    a_addr_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (rsp.status != 3'(bpa_pkg::ST_OK))) |-> (rsp.result_address == '0))
        else $error("failed transaction returned a non-zero address");

    a_accept_check: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> (state_reg == bpa_pkg::S_CHECK))
        else $error("accepted request not checked next cycle");
`endif

endmodule

// ===== src/bpa_ram.sv =====
// bpa_ram: generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module bpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata <= mem[raddr];
    end

endmodule

// ===== dv/bpa_checker.sv =====
// bpa_checker: watches both channels of buddy_page_allocator, predicts each response and compares.
// Depends on bpa_pkg; hands its failure count to tb.
module bpa_checker (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    input  logic          req_ready,
    input  bpa_pkg::req_t req,
    input  logic          rsp_valid,
    input  logic          rsp_ready,
    input  bpa_pkg::rsp_t rsp,
    output int            fail_count,
    output int            pending
);
    import bpa_pkg::*;

    localparam int TBL = TABLE_FRAMES;

    logic [5:0]  marks [TBL];
    int          nxt [TBL];
    int          prv [TBL];
    int          head [LIST_N];
    int          tail [LIST_N];
    logic [31:0] reg_lo;
    logic [31:0] reg_hi;
    rsp_t        awaited_rsp [$];

    assign pending = awaited_rsp.size();

    function automatic void mark_block(int f, bit fr, int ord);
        if (f >= TBL)
            return;
        marks[f] = (marks[f] & 6'h10) | (fr ? 6'h20 : 6'h00) | 6'(ord & 'hF);
    endfunction

    function automatic void list_push(int o, int x);
        int t;
        if (x >= TBL || o > TOP_ORDER)
            return;
        t = tail[o];
        nxt[x] = TBL;
        prv[x] = t;
        if (t >= TBL)
            head[o] = x;
        else
            nxt[t] = x;
        tail[o] = x;
    endfunction

    function automatic void list_unlink(int o, int x);
        int p;
        int n;
        if (x >= TBL || o > TOP_ORDER)
            return;
        p = prv[x] < TBL ? prv[x] : TBL;
        n = nxt[x] < TBL ? nxt[x] : TBL;
        if (p < TBL)
            nxt[p] = n;
        else
            head[o] = n;
        if (n < TBL)
            prv[n] = p;
        else
            tail[o] = p;
    endfunction

    function automatic int order_for(int n);
        int o;
        o = 0;
        while (o <= TOP_ORDER && (1 << o) < n)
            o++;
        return o;
    endfunction

    function automatic void merge_release(int f);
        int ord;
        int bd;
        logic [5:0] m;
        if (f >= TBL)
            return;
        ord = marks[f] & 'hF;
        if (ord > TOP_ORDER)
            return;
        forever
        begin
            marks[f] = marks[f] | 6'h20;
            if (ord >= TOP_ORDER)
                break;
            bd = f ^ (1 << ord);
            if (bd >= TBL)
                break;
            m = marks[bd];
            if (int'(m & 6'hF) != ord || !m[MK_VALID] || !m[MK_FREE])
                break;
            list_unlink(ord, bd);
            f = f & bd;
            mark_block(f ^ (1 << ord), 0, 'hF);
            ord++;
            marks[f] = (marks[f] & 6'h30) | 6'(ord);
        end
        list_push(ord, f);
    endfunction

    function automatic rsp_t predict_response(req_t q);
        rsp_t  r;
        int    n;
        int    f;
        int    k;
        int    od;
        int    cur;
        int    rest;
        int    o;
        logic [32:0] span;
        r = '0;
        n = q.frame_count;
        f = q.byte_address >> PAGE_SHIFT;
        case (q.cmd)
            CMD_INIT:
            begin
                if (q.byte_address[11:0] != 0)
                    r.status = ST_MISALIGNED;
                else if (n == 0)
                    r.status = ST_BAD_COUNT;
                else if (f + n > TBL)
                    r.status = ST_OUT_OF_REGION;
                else
                begin
                    reg_lo = q.byte_address;
                    reg_hi = q.byte_address + (32'(n) << PAGE_SHIFT);
                    for (int i = 0; i < LIST_N; i++)
                    begin
                        head[i] = TBL;
                        tail[i] = TBL;
                    end
                    for (int i = 0; i < n; i++)
                        marks[f + i] = 6'h3F;
                    rest = n;
                    while (rest > 0)
                    begin
                        o = TOP_ORDER;
                        while (o > 0 && ((f & ((1 << o) - 1)) != 0 || (1 << o) > rest))
                            o--;
                        mark_block(f, 1, o);
                        list_push(o, f);
                        f += 1 << o;
                        rest -= 1 << o;
                    end
                end
            end
            CMD_ALLOC:
            begin
                k = order_for(n);
                if (n == 0 || k > TOP_ORDER)
                    r.status = ST_BAD_COUNT;
                else
                begin
                    od = k;
                    while (od <= TOP_ORDER && head[od] >= TBL)
                        od++;
                    if (od > TOP_ORDER)
                        r.status = ST_NO_BLOCK;
                    else
                    begin
                        f = head[od];
                        list_unlink(od, f);
                        mark_block(f, 0, k);
                        while (od > k)
                        begin
                            od--;
                            mark_block(f + (1 << od), 1, od);
                            list_push(od, f + (1 << od));
                        end
                        if (n != (1 << k))
                        begin
                            cur = f;
                            for (int d = k - 1; d >= 0; d--)
                                if (n[d])
                                begin
                                    mark_block(cur, 0, d);
                                    cur += 1 << d;
                                end
                            rest = (1 << k) - n;
                            for (int d = 0; d < k; d++)
                                if (rest[d])
                                begin
                                    mark_block(cur, 1, d);
                                    list_push(d, cur);
                                    cur += 1 << d;
                                end
                        end
                        r.result_address = 32'(f) << PAGE_SHIFT;
                    end
                end
            end
            CMD_FREE:
            begin
                span = 33'(f) + 33'(n);
                if (!(reg_lo <= q.byte_address && q.byte_address < reg_hi))
                    r.status = ST_OUT_OF_REGION;
                else if (q.byte_address[11:0] != 0)
                    r.status = ST_MISALIGNED;
                else if (n == 0 || order_for(n) > TOP_ORDER)
                    r.status = ST_BAD_COUNT;
                else if (span > 33'(reg_hi >> PAGE_SHIFT))
                    r.status = ST_OUT_OF_REGION;
                else
                    for (int d = TOP_ORDER; d >= 0; d--)
                        if (n[d])
                        begin
                            merge_release(f);
                            f += 1 << d;
                        end
            end
            default: ;
        endcase
        if (r.status != ST_OK)
            r.result_address = '0;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        rsp_t want;
        if (!rst_n)
        begin
            fail_count <= 0;
            awaited_rsp.delete();
            reg_lo = '0;
            reg_hi = '0;
            for (int i = 0; i < TBL; i++)
            begin
                marks[i] = '0;
                nxt[i] = 0;
                prv[i] = 0;
            end
            for (int i = 0; i < LIST_N; i++)
            begin
                head[i] = TBL;
                tail[i] = TBL;
            end
        end
        else
        begin
            if (req_valid && req_ready)
                awaited_rsp.push_back(predict_response(req));
            if (rsp_valid && rsp_ready)
            begin
                if (awaited_rsp.size() == 0)
                begin
                    $display("%0t: unexpected response %h", $time, rsp);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = awaited_rsp.pop_front();
                    if (rsp.status != want.status ||
                        rsp.result_address != want.result_address)
                    begin
                        $display("%0t: mismatch: expected status %0d addr %h, got status %0d addr %h",
                                 $time, want.status, want.result_address,
                                 rsp.status, rsp.result_address);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

// ===== dv/tb.sv =====
// tb: stimulus and verdict for buddy_page_allocator.
// Depends on bpa_pkg and bpa_checker, which predicts and compares every response.
module tb;
    import bpa_pkg::*;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_ready;
    req_t req;
    logic rsp_valid;
    logic rsp_ready;
    rsp_t rsp;
    int   fail_count;
    int   pending;

    // idle rates, percent
    int   send_idle;
    int   recv_idle;
    int   quiet_cycles;
    // frames and region of the current init, so frees land where they matter
    int   lay_start;
    int   lay_frames;
    int   held_addr [$];
    int   held_size [$];

    localparam int WATCHDOG = 200000;

    buddy_page_allocator uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    bpa_checker chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req        (req),
        .rsp_valid  (rsp_valid),
        .rsp_ready  (rsp_ready),
        .rsp        (rsp),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // receiver: ready toggles at random on the falling edge
    always @(negedge clk)
        rsp_ready <= ($urandom_range(99) >= recv_idle);

    // watchdog: cycles with no transaction on either channel
    always @(posedge clk)
    begin
        if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG)
        begin
            $display("tb: done, errors");
            $finish;
        end
    end

    // one transaction; valid stays high until taken, then an optional gap
    task automatic send(input cmd_t c, input logic [31:0] a, input int n);
        @(negedge clk);
        req_valid <= 1'b1;
        req.cmd <= c;
        req.byte_address <= a;
        req.frame_count <= 13'(n);
        do
            @(posedge clk);
        while (!req_ready);
        @(negedge clk);
        req_valid <= 1'b0;
        while ($urandom_range(99) < send_idle)
            @(negedge clk);
    endtask

    task automatic send_init(input int start, input int frames);
        lay_start = start;
        lay_frames = frames;
        held_addr.delete();
        held_size.delete();
        send(CMD_INIT, 32'(start) << PAGE_SHIFT, frames);
    endtask

    // random item, mostly well-formed alloc/free pairs inside the region
    task automatic random_item();
        int pick;
        int n;
        int i;
        pick = $urandom_range(99);
        if (pick < 3)
            send_init($urandom_range(2) == 0 ? 0 : $urandom_range(3000),
                      $urandom_range(1, 1096));
        else if (pick < 45)
        begin
            n = $urandom_range(3) == 0 ? $urandom_range(1, 1024) : $urandom_range(1, 40);
            send(CMD_ALLOC, $urandom, n);
            // remember the size only; later frees pick a random frame in the region
            held_addr.push_back(-1);
            held_size.push_back(n);
        end
        else if (pick < 85 && held_addr.size() > 0)
        begin
            i = $urandom_range(held_addr.size() - 1);
            n = held_size[i];
            held_addr.delete(i);
            held_size.delete(i);
            send(CMD_FREE, 32'(lay_start + $urandom_range(lay_frames - 1)) << PAGE_SHIFT,
                 $urandom_range(1, n));
        end
        else if (pick < 93)
            send(CMD_FREE, 32'(lay_start + $urandom_range(lay_frames - 1)) << PAGE_SHIFT,
                 $urandom_range(1, 64));
        else
            send(cmd_t'($urandom_range(3)), $urandom, $urandom_range(8191));
    endtask

    initial
    begin
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        rsp_ready = 1'b0;
        quiet_cycles = 0;
        send_idle = 0;
        recv_idle = 0;
        lay_start = 0;
        lay_frames = 1;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: checks before any region, misaligned, bad counts, out of region, odd command code
        send(CMD_ALLOC, 32'h0, 1);
        send(CMD_FREE, 32'h0, 1);
        send(CMD_INIT, 32'h0000_0001, 4);
        send(CMD_INIT, 32'h0, 0);
        send(CMD_INIT, 32'hFFFF_F000, 2);
        send(CMD_INIT, 32'h0, 4097);
        send(cmd_t'(2'd3), 32'hFFFF_FFFF, 13'h1FFF);
        // whole table, then region ending before a 1024 boundary
        send_init(0, 4096);
        send(CMD_ALLOC, 32'hFFFF_FFFF, 1025);
        send(CMD_ALLOC, 32'h0, 0);
        send(CMD_ALLOC, 32'h0, 1024);
        send(CMD_ALLOC, 32'h0, 3);
        send(CMD_ALLOC, 32'h0, 1);
        send(CMD_FREE, 32'h0000_0001, 1);
        send(CMD_FREE, 32'h0, 0);
        send(CMD_FREE, 32'h0, 1025);
        send(CMD_FREE, 32'h0, 3);
        send(CMD_FREE, 32'h0040_0000, 1024);
        send(CMD_FREE, 32'h0FFF_F000, 2);
        send(CMD_FREE, 32'h1000_0000, 1);
        send(CMD_FREE, 32'h0000_1000, 1);
        send_init(5, 300);
        send(CMD_ALLOC, 32'h0, 7);
        send(CMD_ALLOC, 32'h0, 1024);
        send(CMD_FREE, 32'h0000_5000, 7);

        // random phases with shifting idle patterns
        for (int ph = 0; ph < 3; ph++)
        begin
            send_idle = ph == 0 ? 15 : (ph == 1 ? 81 : 0);
            recv_idle = ph == 0 ? 81 : (ph == 1 ? 15 : 0);
            repeat (250)
                random_item();
        end

        while (pending != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (fail_count == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule
